// ----- hdl/mteu_pkg.sv -----
// Shared types, constants and helper functions for the multi-turn encoder unwrap block.
// This package has no dependencies; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mteu_pkg;

   localparam int MOTORS_DEFAULT = 4;
   localparam int NUM_OFFSETS = 4;
   localparam int OFFSET_IDX_W = 2;
   localparam int CSR_INDEX_W = 4;

   localparam int CAN_ID_W = 10;
   localparam int ANGLE_W = 13;
   localparam int SPEED_W = 16;
   localparam int OFFSET_W = 10;
   localparam int TURN_W = 24;
   localparam int ABS_W = 43;
   localparam int MOTOR_INDEX_W = 2;

   localparam logic [CAN_ID_W-1:0] ID_BASE = 10'h205;
   localparam logic [ANGLE_W-1:0] ZONE_LOW_LIMIT = 13'd2730;
   localparam logic [ANGLE_W-1:0] ZONE_HIGH_LIMIT = 13'd5461;

   localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sh7FFFFF;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 24'sh800000;

   typedef logic [1:0] zone_type;

   localparam zone_type ZONE_MID = 2'd0;
   localparam zone_type ZONE_LOW = 2'd1;
   localparam zone_type ZONE_HIGH = 2'd2;

   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef offset_type [NUM_OFFSETS-1:0] offset_array_type;

   localparam offset_array_type OFFSET_RESET = '{
      10'sd105, 10'sd120, -10'sd60, -10'sd75
   };

   typedef struct packed {
      logic     wr_en;
      zone_type zone;
   } upd_type;

   function automatic zone_type zone_of(input logic [ANGLE_W-1:0] angle);
      zone_type z;
      if (angle < ZONE_LOW_LIMIT) begin
         z = ZONE_LOW;
      end else if (angle > ZONE_HIGH_LIMIT) begin
         z = ZONE_HIGH;
      end else begin
         z = ZONE_MID;
      end
      return z;
   endfunction

endpackage

// ----- hdl/mteu_state.sv -----
// Per-motor zone and turn counter registers with the saturating turn update.
// Depends on mteu_pkg for the zone codes, turn limits and the update struct.
`timescale 1ns / 1ps

module mteu_state #(
   parameter int MOTORS = mteu_pkg::MOTORS_DEFAULT,
   parameter int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mteu_pkg::upd_type                      upd,
   input  logic [IDX_W-1:0]                       idx,
   output logic signed [mteu_pkg::TURN_W-1:0]     turn_new
);

   mteu_pkg::zone_type                      zone_ff [MOTORS];
   mteu_pkg::zone_type                      zone_in [MOTORS];
   logic signed [mteu_pkg::TURN_W-1:0]      turns_ff [MOTORS];
   logic signed [mteu_pkg::TURN_W-1:0]      turns_in [MOTORS];
   mteu_pkg::zone_type                      zone_old;
   logic signed [mteu_pkg::TURN_W-1:0]      turn_old;
   logic                                    step_up;
   logic                                    step_down;

   assign zone_old = zone_ff[idx];
   assign turn_old = turns_ff[idx];
   assign step_up = (zone_old == mteu_pkg::ZONE_HIGH) && (upd.zone == mteu_pkg::ZONE_LOW);
   assign step_down = (zone_old == mteu_pkg::ZONE_LOW) && (upd.zone == mteu_pkg::ZONE_HIGH);

   always_comb begin
      turn_new = turn_old;
      if (step_up && (turn_old != mteu_pkg::TURN_MAX)) begin
         turn_new = turn_old + 24'sd1;
      end else if (step_down && (turn_old != mteu_pkg::TURN_MIN)) begin
         turn_new = turn_old - 24'sd1;
      end
   end

   always_comb begin
      for (int i = 0; i < MOTORS; i++) begin
         zone_in[i] = zone_ff[i];
         turns_in[i] = turns_ff[i];
         if (upd.wr_en && (idx == IDX_W'(i))) begin
            zone_in[i] = upd.zone;
            turns_in[i] = turn_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTORS; i++) begin
            zone_ff[i] <= mteu_pkg::ZONE_MID;
            turns_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < MOTORS; i++) begin
            zone_ff[i] <= zone_in[i];
            turns_ff[i] <= turns_in[i];
         end
      end
   end

   a_turn_up: assert property (@(posedge clock) disable iff (reset)
      (upd.wr_en && step_up && (turn_old != mteu_pkg::TURN_MAX))
      |=> (turns_ff[$past(idx)] == $past(turn_old) + 24'sd1))
      else $error("turn count did not advance on a high to low crossing");

   a_turn_down: assert property (@(posedge clock) disable iff (reset)
      (upd.wr_en && step_down && (turn_old != mteu_pkg::TURN_MIN))
      |=> (turns_ff[$past(idx)] == $past(turn_old) - 24'sd1))
      else $error("turn count did not retreat on a low to high crossing");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (upd.wr_en && (upd.zone == mteu_pkg::ZONE_MID))
      |=> (turns_ff[$past(idx)] == $past(turn_old)))
      else $error("turn count moved on an update into the middle zone");

endmodule

// ----- hdl/mteu_angle.sv -----
// Absolute angle arithmetic: 45 times the combined turn and angle word plus the offset.
// Depends on mteu_pkg for the field widths.
`timescale 1ns / 1ps

module mteu_angle (
   input  logic signed [mteu_pkg::TURN_W-1:0]    turns,
   input  logic [mteu_pkg::ANGLE_W-1:0]          angle,
   input  logic signed [mteu_pkg::OFFSET_W-1:0]  offset,
   output logic signed [mteu_pkg::ABS_W-1:0]     abs_angle
);

   // One turn is 8192 counts, so turns*368640 + angle*45 is 45 times {turns, angle}.
   logic signed [mteu_pkg::ABS_W-1:0] counts;
   logic signed [mteu_pkg::ABS_W-1:0] offset_q10;

   assign counts = mteu_pkg::ABS_W'($signed({turns, angle}));
   assign offset_q10 = mteu_pkg::ABS_W'(offset) <<< 10;
   assign abs_angle = (counts <<< 5) + (counts <<< 3) + (counts <<< 2) + counts + offset_q10;

endmodule

// ----- hdl/multi_turn_encoder_unwrap_top.sv -----
// Each accepted item is a motor feedback report: a frame identifier from 0x205 upward, a
// 13-bit rotor angle and a signed speed. Reports for identifiers outside the configured motor
// range are dropped without a result. Every other report yields one result on the rsp_ port:
// the accepting edge loads the input register, and the result register then takes the outcome
// of the turn update and angle arithmetic from it once the result register is free. A new item
// is accepted in every cycle unless the input register is full and the result register is held
// by a stalled consumer. The user must write offsets through the csr_ port only while the
// block is idle; the block itself does not enforce this. csr_index values beyond the four
// offset registers are ignored.
`timescale 1ns / 1ps

module multi_turn_encoder_unwrap_top #(
   parameter int MOTORS = mteu_pkg::MOTORS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [mteu_pkg::CAN_ID_W-1:0]               req_can_id,
   input  logic [mteu_pkg::ANGLE_W-1:0]                req_angle_raw,
   input  logic signed [mteu_pkg::SPEED_W-1:0]         req_speed_raw,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [mteu_pkg::MOTOR_INDEX_W-1:0]          rsp_motor_index,
   output logic signed [mteu_pkg::SPEED_W-1:0]         rsp_speed_out,
   output logic signed [mteu_pkg::TURN_W-1:0]          rsp_turn_count,
   output logic signed [mteu_pkg::ABS_W-1:0]           rsp_abs_angle,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [mteu_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic signed [mteu_pkg::OFFSET_W-1:0]        csr_wdata
);

   localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   logic                                        s1_valid_ff;
   logic                                        s1_valid_in;
   logic [mteu_pkg::CAN_ID_W-1:0]               s1_id_ff;
   logic [mteu_pkg::ANGLE_W-1:0]                s1_angle_ff;
   logic signed [mteu_pkg::SPEED_W-1:0]         s1_speed_ff;

   logic                                        out_valid_ff;
   logic                                        out_valid_in;
   logic [mteu_pkg::MOTOR_INDEX_W-1:0]          out_index_ff;
   logic signed [mteu_pkg::SPEED_W-1:0]         out_speed_ff;
   logic signed [mteu_pkg::TURN_W-1:0]          out_turn_ff;
   logic signed [mteu_pkg::ABS_W-1:0]           out_abs_ff;

   mteu_pkg::offset_array_type                  offset_ff;

   logic [mteu_pkg::CAN_ID_W-1:0]               id_diff;
   logic                                        id_ok;
   logic [IDX_W-1:0]                            idx;
   logic                                        out_free;
   logic                                        req_fire;
   logic                                        s1_advance;
   mteu_pkg::upd_type                           upd;
   logic signed [mteu_pkg::TURN_W-1:0]          turn_new;
   logic signed [mteu_pkg::OFFSET_W-1:0]        offset_sel;
   logic [IDX_W+mteu_pkg::OFFSET_IDX_W-1:0]     idx_wide;
   logic signed [mteu_pkg::ABS_W-1:0]           abs_angle;

   assign id_diff = s1_id_ff - mteu_pkg::ID_BASE;
   assign id_ok = (s1_id_ff >= mteu_pkg::ID_BASE) && (id_diff < mteu_pkg::CAN_ID_W'(MOTORS));
   assign idx = id_diff[IDX_W-1:0];

   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire = req_valid && req_ready;
   assign s1_valid_in = req_fire ? 1'b1 : (s1_valid_ff && !s1_advance);
   assign out_valid_in = out_free ? (s1_valid_ff && id_ok) : out_valid_ff;

   assign upd.wr_en = s1_advance && id_ok;
   assign upd.zone = mteu_pkg::zone_of(s1_angle_ff);

   assign idx_wide = (IDX_W + mteu_pkg::OFFSET_IDX_W)'(idx);

   always_comb begin
      offset_sel = '0;
      for (int i = 0; i < mteu_pkg::NUM_OFFSETS; i++) begin
         if (idx_wide == (IDX_W + mteu_pkg::OFFSET_IDX_W)'(i)) begin
            offset_sel = offset_ff[i];
         end
      end
   end

   mteu_state #(
      .MOTORS (MOTORS),
      .IDX_W  (IDX_W)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .idx      (idx),
      .turn_new (turn_new)
   );

   mteu_angle u_angle (
      .turns     (turn_new),
      .angle     (s1_angle_ff),
      .offset    (offset_sel),
      .abs_angle (abs_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_id_ff <= req_can_id;
         s1_angle_ff <= req_angle_raw;
         s1_speed_ff <= req_speed_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.wr_en) begin
         out_index_ff <= mteu_pkg::MOTOR_INDEX_W'(idx);
         out_speed_ff <= s1_speed_ff;
         out_turn_ff <= turn_new;
         out_abs_ff <= abs_angle;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= mteu_pkg::OFFSET_RESET;
      end else if (csr_valid && csr_ready
                   && (csr_index < mteu_pkg::CSR_INDEX_W'(mteu_pkg::NUM_OFFSETS))) begin
         offset_ff[csr_index[mteu_pkg::OFFSET_IDX_W-1:0]] <= csr_wdata;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_motor_index = out_index_ff;
   assign rsp_speed_out = out_speed_ff;
   assign rsp_turn_count = out_turn_ff;
   assign rsp_abs_angle = out_abs_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_id_ff)))
      else $error("input stage lost an item while the result register was blocked");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ready && !s1_valid_ff) |=> !out_valid_ff)
      else $error("a result was repeated after it was taken");

   a_bad_id: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !id_ok) |-> !upd.wr_en)
      else $error("an unknown identifier updated motor state");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input not ready while the input stage is empty");

endmodule

// ----- sim/tb_multi_turn_encoder_unwrap_top.sv -----
// Testbench for multi_turn_encoder_unwrap_top: feedback reports go in, and each result is
// compared with a turn-tracking model kept here. Depends on mteu_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_multi_turn_encoder_unwrap_top;

   localparam int MOTORS = mteu_pkg::MOTORS_DEFAULT;
   localparam int NOFF = mteu_pkg::NUM_OFFSETS;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASE_ITEMS = 500;
   localparam int SETTLE_CYCLES = 4;
   localparam int LIMIT_CYCLES = 300000;
   localparam int DEG_Q10_PER_COUNT = 45;
   localparam int Q10_PER_TURN = 368640;
   localparam int Q10_PER_DEGREE = 1024;
   localparam logic [3:0] REG_UNUSED_FIRST = 4'(NOFF);
   localparam logic [3:0] REG_UNUSED_LAST = 4'hF;
   localparam int OFFSET_AT_RESET [NOFF] = '{-75, -60, 120, 105};
   localparam logic [12:0] EDGE_ANGLES [8] = '{0, 2729, 2730, 2731, 5460, 5461, 5462, 8191};

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_pattern_type;

   typedef struct {
      logic [1:0]         motor;
      logic signed [15:0] speed;
      logic signed [23:0] turns;
      logic signed [42:0] angle;
   } motor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [mteu_pkg::CAN_ID_W-1:0] req_can_id = '0;
   logic [mteu_pkg::ANGLE_W-1:0] req_angle_raw = '0;
   logic signed [mteu_pkg::SPEED_W-1:0] req_speed_raw = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [mteu_pkg::MOTOR_INDEX_W-1:0] rsp_motor_index;
   logic signed [mteu_pkg::SPEED_W-1:0] rsp_speed_out;
   logic signed [mteu_pkg::TURN_W-1:0] rsp_turn_count;
   logic signed [mteu_pkg::ABS_W-1:0] rsp_abs_angle;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mteu_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic signed [mteu_pkg::OFFSET_W-1:0] csr_wdata = '0;

   mteu_pkg::offset_type model_offset [NOFF];
   mteu_pkg::zone_type model_zone [MOTORS];
   logic signed [23:0] model_turns [MOTORS];
   motor_result_type pending_results [$];

   logic [12:0] spin_angle [MOTORS];
   logic spin_reverse [MOTORS];
   int burst_left = 0;
   int hold_requests = 0;
   int hold_length = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mode_left = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;

   int cycle_count = 0;
   int mismatch_count = 0;
   int reports_sent = 0;
   int ignored_ids = 0;
   int results_checked = 0;
   int turn_ups = 0;
   int turn_downs = 0;
   int offset_settings = 0;
   int input_stall_cycles = 0;

   multi_turn_encoder_unwrap_top #(
      .MOTORS(MOTORS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_can_id(req_can_id),
      .req_angle_raw(req_angle_raw),
      .req_speed_raw(req_speed_raw),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_motor_index(rsp_motor_index),
      .rsp_speed_out(rsp_speed_out),
      .rsp_turn_count(rsp_turn_count),
      .rsp_abs_angle(rsp_abs_angle),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && !req_ready) begin
         input_stall_cycles <= input_stall_cycles + 1;
      end
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timeout with %0d results outstanding.", pending_results.size());
         $display("FAIL multi_turn_encoder_unwrap_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = hold_length;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 150);
         end else begin
            mode_left = mode_left - 1;
         end
         case (ready_pattern)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      motor_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("Result for motor %0d arrived with no report waiting.", rsp_motor_index);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_motor_index !== want.motor) begin
               $error("motor_index: expected %0d, actual %0d", want.motor, rsp_motor_index);
               mismatch_count++;
            end
            if (rsp_speed_out !== want.speed) begin
               $error("speed_out: expected %0d, actual %0d", want.speed, rsp_speed_out);
               mismatch_count++;
            end
            if (rsp_turn_count !== want.turns) begin
               $error("turn_count: expected %0d, actual %0d", want.turns, rsp_turn_count);
               mismatch_count++;
            end
            if (rsp_abs_angle !== want.angle) begin
               $error("abs_angle: expected %0d, actual %0d", want.angle, rsp_abs_angle);
               mismatch_count++;
            end
         end
      end
   end

   function automatic bit unwrap_report(input logic [9:0] id, input logic [12:0] angle,
                                        input logic signed [15:0] speed,
                                        output motor_result_type res);
      logic [9:0] rel;
      int m;
      mteu_pkg::zone_type now_zone;
      mteu_pkg::zone_type old_zone;
      longint raw_part;
      longint turn_part;
      longint offset_part;
      longint total;
      rel = id - mteu_pkg::ID_BASE;
      res = '{default: '0};
      if (id < mteu_pkg::ID_BASE || rel >= MOTORS) begin
         return 1'b0;
      end
      m = rel;
      if (angle < mteu_pkg::ZONE_LOW_LIMIT) begin
         now_zone = mteu_pkg::ZONE_LOW;
      end else if (angle > mteu_pkg::ZONE_HIGH_LIMIT) begin
         now_zone = mteu_pkg::ZONE_HIGH;
      end else begin
         now_zone = mteu_pkg::ZONE_MID;
      end
      old_zone = model_zone[m];
      if (old_zone == mteu_pkg::ZONE_HIGH && now_zone == mteu_pkg::ZONE_LOW) begin
         if (model_turns[m] != mteu_pkg::TURN_MAX) begin
            model_turns[m] = model_turns[m] + 24'sd1;
            turn_ups++;
         end
      end else if (old_zone == mteu_pkg::ZONE_LOW && now_zone == mteu_pkg::ZONE_HIGH) begin
         if (model_turns[m] != mteu_pkg::TURN_MIN) begin
            model_turns[m] = model_turns[m] - 24'sd1;
            turn_downs++;
         end
      end
      model_zone[m] = now_zone;
      raw_part = angle;
      turn_part = model_turns[m];
      offset_part = 0;
      if (m < NOFF) begin
         offset_part = model_offset[m];
      end
      total = raw_part * DEG_Q10_PER_COUNT + turn_part * Q10_PER_TURN
            + offset_part * Q10_PER_DEGREE;
      res.motor = 2'(m);
      res.speed = speed;
      res.turns = model_turns[m];
      res.angle = total[42:0];
      return 1'b1;
   endfunction

   task automatic send_report(input logic [9:0] id, input logic [12:0] angle,
                              input logic signed [15:0] speed);
      motor_result_type res;
      req_valid <= 1'b1;
      req_can_id <= id;
      req_angle_raw <= angle;
      req_speed_raw <= speed;
      do @(posedge clock); while (!req_ready);
      reports_sent++;
      if (unwrap_report(id, angle, speed, res)) begin
         pending_results.push_back(res);
      end else begin
         ignored_ids++;
      end
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [3:0] idx, input logic signed [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NOFF) begin
         model_offset[idx] = value;
      end
   endtask

   task automatic set_offsets(input logic signed [9:0] o0, input logic signed [9:0] o1,
                              input logic signed [9:0] o2, input logic signed [9:0] o3,
                              input logic [3:0] unused_idx);
      mteu_pkg::offset_type values [NOFF];
      values = '{o0, o1, o2, o3};
      drain_results();
      for (int i = 0; i < NOFF; i++) begin
         write_register(4'(i), values[i]);
      end
      write_register(unused_idx, 10'($urandom));
      csr_valid <= 1'b0;
      offset_settings++;
   endtask

   task automatic test_reset_offsets();
      send_report(mteu_pkg::ID_BASE + 10'd0, 13'd4096, 16'sd0);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd4096, -16'sd32768);
      send_report(mteu_pkg::ID_BASE + 10'd2, 13'd4096, 16'sd32767);
      send_report(mteu_pkg::ID_BASE + 10'd3, 13'd4096, -16'sd1);
   endtask

   task automatic test_zone_crossings();
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd5462, 16'sd100);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd2729, 16'sd200);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd5462, -16'sd200);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd2730, 16'sd5);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd5461, 16'sd6);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd8191, 16'sd7);
      send_report(mteu_pkg::ID_BASE + 10'd1, 13'd0, 16'sd8);
      send_report(mteu_pkg::ID_BASE + 10'd2, 13'd0, 16'sd9);
      send_report(mteu_pkg::ID_BASE + 10'd2, 13'd8191, 16'sd10);
      send_report(mteu_pkg::ID_BASE + 10'd2, 13'd4000, 16'sd11);
   endtask

   task automatic test_unknown_ids();
      send_report(mteu_pkg::ID_BASE - 10'd1, 13'd100, 16'sd1);
      send_report(mteu_pkg::ID_BASE + 10'(MOTORS), 13'd8000, 16'sd2);
      send_report(10'd0, 13'd0, 16'sd3);
      send_report(10'h3FF, 13'h1FFF, -16'sd1);
      send_report(10'h1FF, 13'd6000, 16'sd4);
      send_report(mteu_pkg::ID_BASE + 10'd3, 13'd6000, 16'sd5);
   endtask

   task automatic test_offset_registers();
      set_offsets(-10'sd360, 10'sd360, -10'sd512, 10'sd511, REG_UNUSED_FIRST);
      for (int m = 0; m < MOTORS; m++) begin
         send_report(mteu_pkg::ID_BASE + 10'(m), 13'd8191, 16'(m));
      end
      set_offsets(10'sd360, -10'sd360, 10'sd511, -10'sd512, REG_UNUSED_LAST);
      for (int m = 0; m < MOTORS; m++) begin
         send_report(mteu_pkg::ID_BASE + 10'(m), 13'd0, 16'(m));
      end
      set_offsets(10'sd0, 10'sd0, 10'sd0, 10'sd0, REG_UNUSED_FIRST + 4'd1);
      for (int m = 0; m < MOTORS; m++) begin
         send_report(mteu_pkg::ID_BASE + 10'(m), 13'd2730, 16'(m));
      end
   endtask

   task automatic test_backpressure();
      hold_length = 200;
      hold_requests++;
      for (int i = 0; i < 30; i++) begin
         send_report(mteu_pkg::ID_BASE + 10'($urandom_range(0, MOTORS - 1)),
                     13'($urandom), 16'($urandom));
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      int valid_sent;
      int phase_left;
      int pick;
      int m;
      int step;
      logic [9:0] id;
      logic [12:0] angle;
      logic signed [15:0] speed;
      valid_sent = 0;
      phase_left = PHASE_ITEMS;
      while (valid_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         m = $urandom_range(0, MOTORS - 1);
         id = mteu_pkg::ID_BASE + 10'(m);
         speed = 16'($urandom);
         if (pick < 8) begin
            id = 10'($urandom);
            angle = 13'($urandom);
         end else if (pick < 65) begin
            if ($urandom_range(0, 31) == 0) begin
               spin_reverse[m] = ~spin_reverse[m];
            end
            step = $urandom_range(1, 2600);
            spin_angle[m] = spin_reverse[m] ? spin_angle[m] - 13'(step)
                                            : spin_angle[m] + 13'(step);
            angle = spin_angle[m];
         end else if (pick < 80) begin
            angle = EDGE_ANGLES[$urandom_range(0, 7)];
         end else begin
            angle = 13'($urandom);
         end
         send_report(id, angle, speed);
         if (id >= mteu_pkg::ID_BASE && id - mteu_pkg::ID_BASE < MOTORS) begin
            valid_sent++;
            phase_left--;
         end
         pace_sender();
         if (phase_left == 0) begin
            phase_left = PHASE_ITEMS;
            set_offsets(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                        4'($urandom_range(NOFF, 15)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NOFF; i++) begin
         model_offset[i] = 10'(OFFSET_AT_RESET[i]);
      end
      for (int m = 0; m < MOTORS; m++) begin
         model_zone[m] = mteu_pkg::ZONE_MID;
         model_turns[m] = '0;
         spin_angle[m] = 13'd4096;
         spin_reverse[m] = 1'($urandom_range(0, 1));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_offsets();
      test_zone_crossings();
      test_unknown_ids();
      test_offset_registers();
      test_backpressure();
      test_random_traffic();
      drain_results();

      $display("Covered %0d reports (%0d with unknown ids), %0d results checked, %0d offset sets.",
               reports_sent, ignored_ids, results_checked, offset_settings);
      $display("Turns counted up %0d and down %0d times; input held off for %0d cycles.",
               turn_ups, turn_downs, input_stall_cycles);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS multi_turn_encoder_unwrap_top");
      end else begin
         $display("FAIL multi_turn_encoder_unwrap_top");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mteu_pkg.sv
hdl/mteu_state.sv
hdl/mteu_angle.sv
hdl/multi_turn_encoder_unwrap_top.sv
sim/tb_multi_turn_encoder_unwrap_top.sv
